[rtl/aspc_pkg.sv]
// Shared types for the aliquot sum and perfect-number check block.
package aspc_pkg;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_CHECK,
        S_ADDQ,
        S_FINISH
    } aspc_state_t;

    // Status that the serial divider reports to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Width of the divisor total field on the output.
    localparam int unsigned TOTAL_BITS = 34;

endpackage

[rtl/aliquot_sum_perfect_check_core.sv]
// Top level of the aliquot sum and perfect-number check block.

// This block takes one signed number per transfer and returns the sum of its
// proper divisors together with a flag that is set when the number is perfect.
// Numbers of one or less, zero and negative values give a total of zero and a
// clear flag; they go from the input transfer straight to the finish state and
// from there into the output register. For a larger number n the block tries
// each divisor d from 2 while d does not exceed n / d, and every trial runs
// through one shared bit-serial divider that produces one quotient bit per
// cycle. A trial passes through a start step, the division and a check of
// the remainder, plus a step for the paired quotient when d divides n evenly.
// The last trial, with d one above the integer square root, only ends the
// search, so an item takes about floor(sqrt(n)) trials. Items are handled one
// at a time, and the input is ready again as soon as a result has been moved
// into the output register, even if that result has not yet been taken.
module aliquot_sum_perfect_check_core #(
    parameter int unsigned NUMBER_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Bits from lowest up: number (NUMBER_BITS, signed), zero padding.
    input  logic [((NUMBER_BITS+7)/8)*8-1:0]      s_tdata,
    // Output stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // Bits from lowest up: divisor_total (34, unsigned), zero padding.
    output logic [((aspc_pkg::TOTAL_BITS+7)/8)*8-1:0] m_tdata,
    // Bits from lowest up: perfect (1).
    output logic                                  m_tuser
);

    localparam int unsigned OUT_DATA_BITS = ((aspc_pkg::TOTAL_BITS + 7) / 8) * 8;
    // The unreduced sum of divisors stays below 16 * n, so four spare bits suffice.
    localparam int unsigned SUM_BITS = (NUMBER_BITS + 4 > aspc_pkg::TOTAL_BITS) ?
                                       NUMBER_BITS + 4 : aspc_pkg::TOTAL_BITS;

    aspc_pkg::aspc_state_t state_reg, state_next;

    logic [NUMBER_BITS-1:0]           n_reg, n_next;
    logic [NUMBER_BITS-1:0]           d_reg, d_next;
    logic [SUM_BITS-1:0]              total_reg, total_next;
    logic [aspc_pkg::TOTAL_BITS-1:0]  out_total_reg, out_total_next;
    logic                             out_perfect_reg, out_perfect_next;
    logic                             out_valid_reg, out_valid_next;

    logic [NUMBER_BITS-1:0]  number;
    logic [NUMBER_BITS-1:0]  pos_value;
    logic                    small_value;
    logic                    in_xfer;
    logic                    div_start;
    logic                    out_load;
    aspc_pkg::div_status_t   div_stat;
    logic [NUMBER_BITS-1:0]  quotient;
    logic [NUMBER_BITS-1:0]  remainder;
    logic                    trials_done;

    // Negative inputs are treated as zero: they have no proper divisors here.
    assign number      = s_tdata[NUMBER_BITS-1:0];
    assign pos_value   = number[NUMBER_BITS-1] ? '0 : number;
    assign small_value = (pos_value <= NUMBER_BITS'(1));
    assign in_xfer     = s_tvalid && s_tready;
    // The search stops once the divisor exceeds the quotient, i.e. d * d > n.
    assign trials_done = (d_reg > quotient);

    aspc_div #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .status    (div_stat),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // Next-state logic of the trial sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aspc_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = small_value ? aspc_pkg::S_FINISH : aspc_pkg::S_START;
                end
            end
            aspc_pkg::S_START:
            begin
                state_next = aspc_pkg::S_DIV;
            end
            aspc_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = aspc_pkg::S_CHECK;
                end
            end
            aspc_pkg::S_CHECK:
            begin
                if (trials_done)
                begin
                    state_next = aspc_pkg::S_FINISH;
                end
                else if (remainder == '0)
                begin
                    state_next = aspc_pkg::S_ADDQ;
                end
                else
                begin
                    state_next = aspc_pkg::S_START;
                end
            end
            aspc_pkg::S_ADDQ:
            begin
                state_next = aspc_pkg::S_START;
            end
            aspc_pkg::S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = aspc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = aspc_pkg::S_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            aspc_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
            end
            aspc_pkg::S_START:
            begin
                div_start = 1'b1;
            end
            aspc_pkg::S_FINISH:
            begin
                out_load = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Datapath: operand capture, divisor count and the running total.
    always_comb
    begin
        n_next           = n_reg;
        d_next           = d_reg;
        total_next       = total_reg;
        out_total_next   = out_total_reg;
        out_perfect_next = out_perfect_reg;
        out_valid_next   = out_valid_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            aspc_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    n_next     = pos_value;
                    d_next     = NUMBER_BITS'(2);
                    total_next = small_value ? '0 : SUM_BITS'(1);
                end
            end
            aspc_pkg::S_CHECK:
            begin
                if (!trials_done)
                begin
                    if (remainder == '0)
                    begin
                        total_next = total_reg + {{(SUM_BITS-NUMBER_BITS){1'b0}}, d_reg};
                    end
                    else
                    begin
                        d_next = d_reg + NUMBER_BITS'(1);
                    end
                end
            end
            aspc_pkg::S_ADDQ:
            begin
                // A square root divisor is counted only once.
                if (quotient != d_reg)
                begin
                    total_next = total_reg + {{(SUM_BITS-NUMBER_BITS){1'b0}}, quotient};
                end
                d_next = d_reg + NUMBER_BITS'(1);
            end
            aspc_pkg::S_FINISH:
            begin
                if (out_load)
                begin
                    out_total_next   = total_reg[aspc_pkg::TOTAL_BITS-1:0];
                    out_perfect_next = (n_reg != '0) &&
                        (total_reg == {{(SUM_BITS-NUMBER_BITS){1'b0}}, n_reg});
                    out_valid_next   = 1'b1;
                end
            end
            default:
            begin
                d_next = d_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aspc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        d_reg           <= d_next;
        total_reg       <= total_next;
        out_total_reg   <= out_total_next;
        out_perfect_reg <= out_perfect_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_BITS-aspc_pkg::TOTAL_BITS){1'b0}}, out_total_reg};
    assign m_tuser  = out_perfect_reg;

    // An input of one or less skips the trial loop entirely.
    a_small_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && small_value) |=> (state_reg == aspc_pkg::S_FINISH))
        else $error("small input did not go straight to finish");

    // The divider is only started when it is free.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // The trial divisor must not move while a division is in flight.
    a_div_operand: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == aspc_pkg::S_DIV) |=> $stable(d_reg))
        else $error("divisor changed during division");

    // A perfect number always has a nonzero divisor total.
    a_perfect_total: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (out_total_reg != '0))
        else $error("perfect flag with zero total");

endmodule

[rtl/aspc_div.sv]
// Bit-serial restoring divider: one quotient bit per clock cycle.
module aspc_div #(
    parameter int unsigned NUMBER_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [NUMBER_BITS-1:0]      dividend,
    input  logic [NUMBER_BITS-1:0]      divisor,
    output aspc_pkg::div_status_t       status,
    output logic [NUMBER_BITS-1:0]      quotient,
    output logic [NUMBER_BITS-1:0]      remainder
);

    localparam int unsigned CNT_BITS = $clog2(NUMBER_BITS + 1);

    logic [NUMBER_BITS-1:0] rem_reg, rem_next;
    logic [NUMBER_BITS-1:0] quo_reg, quo_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [NUMBER_BITS:0]   shifted;
    logic [NUMBER_BITS:0]   divisor_ext;
    logic                   fits;

    assign shifted     = {rem_reg, quo_reg[NUMBER_BITS-1]};
    assign divisor_ext = {1'b0, divisor};
    assign fits        = (shifted >= divisor_ext);

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_BITS'(NUMBER_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Shift in the next dividend bit and subtract when the divisor fits.
            if (fits)
            begin
                rem_next = NUMBER_BITS'(shifted - divisor_ext);
            end
            else
            begin
                rem_next = shifted[NUMBER_BITS-1:0];
            end
            quo_next = {quo_reg[NUMBER_BITS-2:0], fits};
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule
